FILE: rtl/rxs_pkg.sv
// Shared types and constants for the record exchange sort unit.
package rxs_pkg;

	localparam int NAME_W = 64;
	localparam int ID_W   = 27;
	localparam int AGE_W  = 7;
	localparam int PART_BYTES = NAME_W / 8;

	typedef struct packed {
		logic              valid;
		logic [NAME_W-1:0] name_high;
		logic [NAME_W-1:0] name_middle;
		logic [NAME_W-1:0] name_low;
		logic [ID_W-1:0]   id;
		logic [AGE_W-1:0]  age;
	} record_t;

	// Result of one 64-bit step of the name compare.
	typedef struct packed {
		logic differ; // parts differ before the end of the string
		logic after;  // a orders after b (meaningful when differ)
		logic term;   // string ends inside this part
	} cmp_res_t;

	typedef enum logic [1:0] {
		PART_HIGH   = 2'd0,
		PART_MIDDLE = 2'd1,
		PART_LOW    = 2'd2
	} part_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_I,
		S_GET_I,
		S_RD_P,
		S_CMP,
		S_WB,
		S_EMIT
	} state_t;

endpackage

FILE: rtl/rxs_name_cmp.sv
// One step of the strcmp-style name compare over a 64-bit part.
module rxs_name_cmp
	import rxs_pkg::*;
(
	input  logic [NAME_W-1:0] a,
	input  logic [NAME_W-1:0] b,
	output cmp_res_t          res
);

	logic [NAME_W-1:0] a_c;
	logic [NAME_W-1:0] b_c;

	// Zero every byte after the first zero byte, first byte in the top bits.
	always_comb begin
		logic za;
		logic zb;
		za = 1'b0;
		zb = 1'b0;
		for (int k = 0; k < PART_BYTES; k++) begin
			a_c[NAME_W-1-8*k -: 8] = za ? 8'h00 : a[NAME_W-1-8*k -: 8];
			b_c[NAME_W-1-8*k -: 8] = zb ? 8'h00 : b[NAME_W-1-8*k -: 8];
			za = za | (a[NAME_W-1-8*k -: 8] == 8'h00);
			zb = zb | (b[NAME_W-1-8*k -: 8] == 8'h00);
		end
		res.term   = za;
		res.differ = (a_c != b_c);
		res.after  = (a_c > b_c);
	end

endmodule

FILE: rtl/record_exchange_sort_by_name_unit.sv
// Top level: record loader, exchange sorter by name, and result emitter.
//
// Usage: present one record on the input ports with start high; it is taken
// at the rising edge where start is high and busy is low. Records fill slots
// 0..CAPACITY-1 in order, one cycle each; further records are dropped and the
// batch is flagged with overflow. A record with final_record high ends the
// batch: busy rises and the unit sorts the loaded slots by name in place.
// For every valid slot i, slot i is read once into a holding register, then
// each later slot p is read from the record memory and compared with it by
// the shared name comparator, one 64-bit part per cycle. An out-of-order
// pair swaps payloads; valid marks stay put. Slot i is then written back;
// an invalid slot i is read and skipped. Sort time is quadratic in the batch
// size n; the memory's single read port and the one comparator set it.
// Emit: n results, one per cycle, each on the output ports for one cycle
// with strobe high; out_last marks the final one. The receiver cannot stall.
// busy falls with the last read, so a new batch may begin while the last
// result is still on the ports. Reset clears the slot count, overflow mark
// and sequencer; the record memory needs no clearing since only slots loaded
// in the current batch are ever read.
module record_exchange_sort_by_name_unit
	import rxs_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              entry_valid,
	input  logic [NAME_W-1:0] name_high,
	input  logic [NAME_W-1:0] name_middle,
	input  logic [NAME_W-1:0] name_low,
	input  logic [ID_W-1:0]   id_number,
	input  logic [AGE_W-1:0]  age_years,
	input  logic              final_record,
	output logic              strobe,
	output logic              out_valid,
	output logic [NAME_W-1:0] out_name_high,
	output logic [NAME_W-1:0] out_name_middle,
	output logic [NAME_W-1:0] out_name_low,
	output logic [ID_W-1:0]   out_id_number,
	output logic [AGE_W-1:0]  out_age,
	output logic              out_last,
	output logic              overflow
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// record memory
	record_t mem [CAPACITY];
	record_t rd_q;
	logic    rd_en;
	logic [AW-1:0] rd_addr;
	logic    we;
	logic [AW-1:0] wa;
	record_t wd;

	// sequencer
	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d; // slots loaded, also n during the sort
	logic [CW-1:0] i_q, i_d;
	logic [CW-1:0] p_q, p_d;
	part_t part_q, part_d;
	logic drop_q, drop_d;

	// slot i held while it is compared with later slots
	record_t cur_q, cur_d;

	logic strobe_s1, last_s1, ovf_s1;
	logic strobe_d, last_d, ovf_d;

	logic [NAME_W-1:0] cmp_a, cmp_b;
	cmp_res_t cmp_res;

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		unique case (part_q)
			PART_HIGH: begin
				cmp_a = cur_q.name_high;
				cmp_b = rd_q.name_high;
			end
			PART_MIDDLE: begin
				cmp_a = cur_q.name_middle;
				cmp_b = rd_q.name_middle;
			end
			default: begin
				cmp_a = cur_q.name_low;
				cmp_b = rd_q.name_low;
			end
		endcase
	end

	rxs_name_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp_res)
	);

	always_comb begin
		logic    fin;
		logic    swap;
		record_t in_rec;
		fin  = 1'b0;
		swap = 1'b0;
		in_rec = '{valid: entry_valid, name_high: name_high, name_middle: name_middle,
			name_low: name_low, id: id_number, age: age_years};

		state_d  = state_q;
		count_d  = count_q;
		i_d      = i_q;
		p_d      = p_q;
		part_d   = part_q;
		drop_d   = drop_q;
		cur_d    = cur_q;
		we       = 1'b0;
		wa       = count_q[AW-1:0];
		wd       = in_rec;
		rd_en    = 1'b0;
		rd_addr  = i_q[AW-1:0];
		strobe_d = 1'b0;
		last_d   = 1'b0;
		ovf_d    = ovf_s1;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (count_q < CAP_C) begin
						we      = 1'b1;
						count_d = count_q + CW'(1);
					end else begin
						drop_d = 1'b1;
					end
					if (final_record) begin
						i_d = '0;
						// a single slot needs no sort
						if (count_d == CW'(1)) state_d = S_EMIT;
						else state_d = S_RD_I;
					end
				end
			end
			S_RD_I: begin
				rd_en   = 1'b1;
				state_d = S_GET_I;
			end
			S_GET_I: begin
				cur_d = rd_q;
				if (rd_q.valid) begin
					p_d     = i_q + CW'(1);
					part_d  = PART_HIGH;
					state_d = S_RD_P;
				end else begin
					// invalid slot swaps with nothing
					i_d = i_q + CW'(1);
					if (i_q + CW'(2) >= count_q) begin
						i_d     = '0;
						state_d = S_EMIT;
					end else begin
						state_d = S_RD_I;
					end
				end
			end
			S_RD_P: begin
				rd_en   = 1'b1;
				rd_addr = p_q[AW-1:0];
				part_d  = PART_HIGH;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (!rd_q.valid) begin
					fin = 1'b1;
				end else if (cmp_res.differ) begin
					fin  = 1'b1;
					swap = cmp_res.after;
				end else if (cmp_res.term || part_q == PART_LOW) begin
					fin = 1'b1;
				end else begin
					part_d = (part_q == PART_HIGH) ? PART_MIDDLE : PART_LOW;
				end
				if (swap) begin
					we = 1'b1;
					wa = p_q[AW-1:0];
					wd = cur_q;
					wd.valid = rd_q.valid;
					cur_d = rd_q;
					cur_d.valid = cur_q.valid;
				end
				if (fin) begin
					p_d = p_q + CW'(1);
					if (p_q + CW'(1) == count_q) state_d = S_WB;
					else state_d = S_RD_P;
				end
			end
			S_WB: begin
				we = 1'b1;
				wa = i_q[AW-1:0];
				wd = cur_q;
				i_d = i_q + CW'(1);
				if (i_q + CW'(2) >= count_q) begin
					i_d     = '0;
					state_d = S_EMIT;
				end else begin
					state_d = S_RD_I;
				end
			end
			S_EMIT: begin
				rd_en    = 1'b1;
				strobe_d = 1'b1;
				ovf_d    = drop_q;
				last_d   = (i_q + CW'(1) == count_q);
				i_d      = i_q + CW'(1);
				if (i_q + CW'(1) == count_q) begin
					count_d = '0;
					drop_d  = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			i_q       <= '0;
			p_q       <= '0;
			part_q    <= PART_HIGH;
			drop_q    <= 1'b0;
			strobe_s1 <= 1'b0;
			last_s1   <= 1'b0;
			ovf_s1    <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			i_q       <= i_d;
			p_q       <= p_d;
			part_q    <= part_d;
			drop_q    <= drop_d;
			strobe_s1 <= strobe_d;
			last_s1   <= last_d;
			ovf_s1    <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
	end

	// record memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem[rd_addr];
	end

	assign strobe          = strobe_s1;
	assign out_valid       = rd_q.valid;
	assign out_name_high   = rd_q.name_high;
	assign out_name_middle = rd_q.name_middle;
	assign out_name_low    = rd_q.name_low;
	assign out_id_number   = rd_q.id;
	assign out_age         = rd_q.age;
	assign out_last        = last_s1;
	assign overflow        = ovf_s1;

endmodule

FILE: dv/tb_record_exchange_sort_by_name_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the record exchange sort by name unit.
module tb_record_exchange_sort_by_name_unit
	import rxs_pkg::*;
();

	localparam int SLOTS        = 32;
	localparam int ITEM_TARGET  = 370;
	// Watchdog limit, well above the time a full batch of 32 valid slots takes to sort.
	localparam int STALL_LIMIT  = 25000;
	localparam int DRAIN_CYCLES = 64;
	localparam int ID_MAX       = 99999999;
	localparam int REPORT_MAX   = 10;
	localparam int NAME_BITS    = 3 * NAME_W;

	// One load transaction as presented on the input ports.
	typedef struct packed {
		record_t rec;
		logic    fin;
	} load_t;

	// One emitted slot as seen on the result ports.
	typedef struct packed {
		record_t rec;
		logic    last;
		logic    ovf;
	} slot_out_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              entry_valid = 1'b0;
	logic [NAME_W-1:0] name_high = '0;
	logic [NAME_W-1:0] name_middle = '0;
	logic [NAME_W-1:0] name_low = '0;
	logic [ID_W-1:0]   id_number = '0;
	logic [AGE_W-1:0]  age_years = '0;
	logic              final_record = 1'b0;
	logic              strobe;
	logic              out_valid;
	logic [NAME_W-1:0] out_name_high;
	logic [NAME_W-1:0] out_name_middle;
	logic [NAME_W-1:0] out_name_low;
	logic [ID_W-1:0]   out_id_number;
	logic [AGE_W-1:0]  out_age;
	logic              out_last;
	logic              overflow;

	load_t     pending_loads[$];      // stimulus not yet driven
	record_t   batch_slots[$];        // predictor copy of the loaded slots
	bit        batch_dropped;         // predictor copy of the overflow mark
	slot_out_t sorted_records_due[$]; // predicted results, oldest first

	int loads_built;
	int loads_issued;
	int records_taken;
	int batches_closed;
	int overflow_batches;
	int swaps_predicted;
	int results_checked;
	int fault_count;
	int stall_cycles;

	record_exchange_sort_by_name_unit #(
		.CAPACITY(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.entry_valid(entry_valid),
		.name_high(name_high),
		.name_middle(name_middle),
		.name_low(name_low),
		.id_number(id_number),
		.age_years(age_years),
		.final_record(final_record),
		.strobe(strobe),
		.out_valid(out_valid),
		.out_name_high(out_name_high),
		.out_name_middle(out_name_middle),
		.out_name_low(out_name_low),
		.out_id_number(out_id_number),
		.out_age(out_age),
		.out_last(out_last),
		.overflow(overflow)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// Byte k of a name, byte 0 being the top byte of the high part.
	function automatic logic [7:0] name_byte(record_t r, int k);
		logic [NAME_W-1:0] w;
		w = (k < 8) ? r.name_high : (k < 16) ? r.name_middle : r.name_low;
		return w[NAME_W-1-8*(k%8) -: 8];
	endfunction

	// strcmp order: unsigned bytes, stop at the first difference or a shared
	// terminator; a name with no zero byte runs the full 24 bytes.
	function automatic bit name_orders_after(record_t a, record_t b);
		logic [7:0] x;
		logic [7:0] y;
		for (int k = 0; k < 24; k++) begin
			x = name_byte(a, k);
			y = name_byte(b, k);
			if (x != y)
				return x > y;
			if (x == 8'h00)
				return 1'b0;
		end
		return 1'b0;
	endfunction

	// Take one accepted load; on the final record sort the batch and queue
	// every loaded slot as an expected result.
	task automatic absorb_record(input load_t item);
		record_t held;
		int      n;
		if (batch_slots.size() < SLOTS)
			batch_slots.push_back(item.rec);
		else
			batch_dropped = 1'b1;
		records_taken++;
		if (item.fin) begin
			n = batch_slots.size();
			for (int i = 0; i + 1 < n; i++) begin
				for (int p = i + 1; p < n; p++) begin
					// Both marks are set whenever a swap happens, so swapping the
					// whole record leaves the valid marks in place.
					if (batch_slots[i].valid && batch_slots[p].valid &&
					    name_orders_after(batch_slots[i], batch_slots[p])) begin
						held = batch_slots[i];
						batch_slots[i] = batch_slots[p];
						batch_slots[p] = held;
						swaps_predicted++;
					end
				end
			end
			for (int i = 0; i < n; i++)
				sorted_records_due.push_back('{rec: batch_slots[i], last: (i == n - 1),
					ovf: batch_dropped});
			if (batch_dropped)
				overflow_batches++;
			batches_closed++;
			batch_slots.delete();
			batch_dropped = 1'b0;
		end
	endtask

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic logic [NAME_BITS-1:0] str_name(string s);
		logic [NAME_BITS-1:0] nm;
		nm = '0;
		for (int k = 0; k < s.len() && k < 24; k++)
			nm[NAME_BITS-1-8*k -: 8] = s[k];
		return nm;
	endfunction

	// Name of len bytes, then a terminator, then either zeros or junk that the
	// ordering must ignore. A narrow alphabet gives many shared prefixes.
	function automatic logic [NAME_BITS-1:0] make_name(int len, bit narrow, bit junk_tail);
		logic [NAME_BITS-1:0] nm;
		logic [7:0]           b;
		nm = '0;
		for (int k = 0; k < 24; k++) begin
			if (k < len)
				b = narrow ? 8'(8'h41 + $urandom_range(2)) : 8'($urandom_range(255, 1));
			else if (k > len && junk_tail)
				b = 8'($urandom_range(255));
			else
				b = 8'h00;
			nm[NAME_BITS-1-8*k -: 8] = b;
		end
		return nm;
	endfunction

	function automatic logic [NAME_BITS-1:0] random_name(logic [NAME_BITS-1:0] prior);
		int pick;
		int k;
		pick = $urandom_range(99);
		if (pick < 10)
			return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if (pick < 22)
			return prior;                 // exact duplicate: must stay unswapped
		if (pick < 32) begin
			k = $urandom_range(23);       // shared prefix of k bytes, byte k replaced
			prior[NAME_BITS-1-8*k -: 8] = 8'($urandom_range(255));
			return prior;
		end
		return make_name(($urandom_range(99) < 70) ? $urandom_range(6) : $urandom_range(24),
			$urandom_range(99) < 70, $urandom_range(99) < 25);
	endfunction

	task automatic queue_load(input bit valid, input logic [NAME_BITS-1:0] nm,
		input int unsigned id, input int unsigned age, input bit fin);
		load_t item;
		item.rec.valid       = valid;
		item.rec.name_high   = nm[NAME_BITS-1 -: NAME_W];
		item.rec.name_middle = nm[2*NAME_W-1 -: NAME_W];
		item.rec.name_low    = nm[NAME_W-1:0];
		item.rec.id          = id[ID_W-1:0];
		item.rec.age         = age[AGE_W-1:0];
		item.fin             = fin;
		pending_loads.push_back(item);
		loads_built++;
	endtask

	// Random batch: mostly valid records, random names, id extremes now and then.
	task automatic queue_batch(input int size);
		logic [NAME_BITS-1:0] nm;
		int unsigned          id;
		nm = '0;
		for (int r = 0; r < size; r++) begin
			nm = random_name(nm);
			if ($urandom_range(99) < 10)
				id = $urandom_range(1) ? ID_MAX : 0;
			else
				id = $urandom_range(ID_MAX);
			queue_load($urandom_range(99) < 80, nm, id, $urandom_range(127), r == size - 1);
		end
	endtask

	// ---------------------------------------------------------------------
	// Driver: one transaction per accept, start held until busy is low.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_loads
		load_t nxt;
		load_t taken;
		bit    rest;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				taken.rec.valid       = entry_valid;
				taken.rec.name_high   = name_high;
				taken.rec.name_middle = name_middle;
				taken.rec.name_low    = name_low;
				taken.rec.id          = id_number;
				taken.rec.age         = age_years;
				taken.fin             = final_record;
				absorb_record(taken);
			end
			if (!start || !busy) begin
				// No idling across a stretch of loads, so back-to-back accepts happen.
				rest = !(loads_issued >= 140 && loads_issued < 220) &&
					($urandom_range(99) < 26);
				if (pending_loads.size() > 0 && !rest) begin
					nxt = pending_loads.pop_front();
					entry_valid  <= nxt.rec.valid;
					name_high    <= nxt.rec.name_high;
					name_middle  <= nxt.rec.name_middle;
					name_low     <= nxt.rec.name_low;
					id_number    <= nxt.rec.id;
					age_years    <= nxt.rec.age;
					final_record <= nxt.fin;
					start        <= 1'b1;
					loads_issued++;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: each strobed result against the oldest prediction.
	// ---------------------------------------------------------------------
	function automatic string differing_fields(slot_out_t want, slot_out_t got);
		string s;
		s = "";
		if (got.rec.valid !== want.rec.valid)             s = {s, " valid"};
		if (got.rec.name_high !== want.rec.name_high)     s = {s, " name_high"};
		if (got.rec.name_middle !== want.rec.name_middle) s = {s, " name_middle"};
		if (got.rec.name_low !== want.rec.name_low)       s = {s, " name_low"};
		if (got.rec.id !== want.rec.id)                   s = {s, " id"};
		if (got.rec.age !== want.rec.age)                 s = {s, " age"};
		if (got.last !== want.last)                       s = {s, " last"};
		if (got.ovf !== want.ovf)                         s = {s, " overflow"};
		return s;
	endfunction

	always @(posedge clk) begin : check_results
		slot_out_t want;
		slot_out_t got;
		string     bad;
		if (arst_n && strobe) begin
			got.rec.valid       = out_valid;
			got.rec.name_high   = out_name_high;
			got.rec.name_middle = out_name_middle;
			got.rec.name_low    = out_name_low;
			got.rec.id          = out_id_number;
			got.rec.age         = out_age;
			got.last            = out_last;
			got.ovf             = overflow;
			if (sorted_records_due.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_MAX)
					$display("%0t: result with nothing expected: name=%h_%h_%h id=%0d",
						$realtime, got.rec.name_high, got.rec.name_middle,
						got.rec.name_low, got.rec.id);
			end else begin
				want = sorted_records_due.pop_front();
				results_checked++;
				bad = differing_fields(want, got);
				if (bad != "") begin
					fault_count++;
					if (fault_count <= REPORT_MAX) begin
						$display("%0t: result %0d mismatch in%s", $realtime, results_checked, bad);
						$display("  exp v=%0b name=%h_%h_%h id=%0d age=%0d last=%0b ovf=%0b",
							want.rec.valid, want.rec.name_high, want.rec.name_middle,
							want.rec.name_low, want.rec.id, want.rec.age, want.last, want.ovf);
						$display("  got v=%0b name=%h_%h_%h id=%0d age=%0d last=%0b ovf=%0b",
							got.rec.valid, got.rec.name_high, got.rec.name_middle,
							got.rec.name_low, got.rec.id, got.rec.age, got.last, got.ovf);
					end
				end
			end
		end
	end

	// Watchdog: cycles in which no transaction and no result moved.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles, %0d results outstanding",
				STALL_LIMIT, sorted_records_due.size());
			$display("tb_record_exchange_sort_by_name_unit: errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus and end of test
	// ---------------------------------------------------------------------
	initial begin : run_test
		logic [NAME_BITS-1:0] bob_junk;
		int                   pick;
		int                   size;

		// Directed: extreme single-record batches.
		queue_load(1'b1, {NAME_BITS{1'b1}}, ID_MAX, 127, 1'b1);
		queue_load(1'b0, '0, 0, 0, 1'b1);

		// Directed: one batch of ordering corner cases.
		bob_junk = str_name("BOB");
		bob_junk[NAME_BITS-1-8*4 -: 24] = "XYZ";  // junk after the terminator
		queue_load(1'b1, str_name("BOBBY"), 11, 30, 1'b0);
		queue_load(1'b1, bob_junk, 12, 31, 1'b0);
		queue_load(1'b1, str_name("BOB"), 13, 32, 1'b0);    // ties with the junk-tail BOB
		queue_load(1'b0, str_name("AAA"), 14, 33, 1'b0);    // empty slot holds its place
		queue_load(1'b1, str_name("ALICE"), 15, 34, 1'b0);
		queue_load(1'b1, '0, 16, 0, 1'b0);                  // empty name sorts first
		queue_load(1'b1, {24{8'hFF}}, 17, 127, 1'b0);       // no terminator at all
		queue_load(1'b1, {24{8'h7F}}, 18, 1, 1'b0);
		queue_load(1'b1, {8'h80, {(NAME_BITS-8){1'b0}}}, 19, 2, 1'b0); // unsigned bytes
		queue_load(1'b1, str_name("MMMMMMMMMMMMMMMMMMMMMMMB"), 20, 3, 1'b0);
		queue_load(1'b1, str_name("MMMMMMMMMMMMMMMMMMMMMMMA"), 21, 4, 1'b0); // last byte
		queue_load(1'b1, str_name("bob"), 22, 5, 1'b0);
		queue_load(1'b1, str_name("ANN"), 0, 6, 1'b1);

		// Store full: records past capacity dropped, final record among them.
		queue_batch(SLOTS + 1);
		queue_batch(SLOTS + 5);

		// Random batches, mostly small so the quadratic sort stays quick.
		while (loads_built < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 60)
				size = $urandom_range(6, 1);
			else if (pick < 85)
				size = $urandom_range(16, 7);
			else if (pick < 95)
				size = $urandom_range(SLOTS, 17);
			else
				size = $urandom_range(SLOTS + 8, SLOTS + 1);
			queue_batch(size);
		end

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_loads.size() != 0 || start || sorted_records_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sorted_records_due.size() != 0) begin
			$display("%0d expected results never arrived", sorted_records_due.size());
			fault_count += sorted_records_due.size();
		end
		$display("%0d records in %0d batches, %0d of them overflowing; %0d swaps predicted",
			records_taken, batches_closed, overflow_batches, swaps_predicted);
		$display("%0d results checked, %0d failures", results_checked, fault_count);
		if (fault_count == 0) begin
			$display("tb_record_exchange_sort_by_name_unit: clean");
		end else begin
			$display("tb_record_exchange_sort_by_name_unit: errors");
		end
		$finish;
	end

endmodule
